### hw/rtl/bls_pkg.sv
// bls_pkg: shared types and constants for the bresenham line stepper
// holds item structs, operation codes and the line state record
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int INC_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int COLOR_BITS = 32;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   operation;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } t_out_item;

    typedef struct packed {
        logic                       active;
        logic                       steep;
        logic                       step_down;
        logic [COORD_BITS-1:0]      maj_pos;
        logic [COORD_BITS-1:0]      maj_end;
        logic [COORD_BITS-1:0]      min_pos;
        logic [COORD_BITS-1:0]      maj_delta;
        logic [INC_BITS-1:0]        min_inc;
        logic signed [ERR_BITS-1:0] err;
    } t_line;

endpackage

`default_nettype wire

### hw/rtl/bls_setup.sv
// bls_setup: works out the stepping state of a new line from its endpoints
// steep swap, endpoint ordering, deltas; purely combinational
// depends on bls_pkg
`timescale 1ns / 1ps
`default_nettype none

module bls_setup (
    input  bls_pkg::t_in_item i_item,
    output bls_pkg::t_line    o_line
);
    import bls_pkg::*;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  steep;
    logic [COORD_BITS-1:0] a_maj;
    logic [COORD_BITS-1:0] a_min;
    logic [COORD_BITS-1:0] b_maj;
    logic [COORD_BITS-1:0] b_min;
    logic [COORD_BITS-1:0] s_maj;
    logic [COORD_BITS-1:0] s_min;
    logic [COORD_BITS-1:0] e_maj;
    logic [COORD_BITS-1:0] e_min;
    logic                  swap;

    always_comb begin
        dx    = abs_diff(i_item.start_x, i_item.end_x);
        dy    = abs_diff(i_item.start_y, i_item.end_y);
        steep = dx < dy;
        if (steep) begin
            a_maj = i_item.start_y;
            a_min = i_item.start_x;
            b_maj = i_item.end_y;
            b_min = i_item.end_x;
        end else begin
            a_maj = i_item.start_x;
            a_min = i_item.start_y;
            b_maj = i_item.end_x;
            b_min = i_item.end_y;
        end
        swap  = a_maj > b_maj;
        s_maj = swap ? b_maj : a_maj;
        s_min = swap ? b_min : a_min;
        e_maj = swap ? a_maj : b_maj;
        e_min = swap ? a_min : b_min;

        o_line.active    = 1'b1;
        o_line.steep     = steep;
        o_line.step_down = s_min > e_min;
        o_line.maj_pos   = s_maj;
        o_line.maj_end   = e_maj;
        o_line.min_pos   = s_min;
        o_line.maj_delta = e_maj - s_maj;
        o_line.min_inc   = {abs_diff(s_min, e_min), 1'b0};
        o_line.err       = '0;
    end

endmodule

`default_nettype wire

### hw/rtl/bls_stepper.sv
// bls_stepper: line state register, one error step per item, result register
// takes the registered input item and the setup record for loads
// depends on bls_pkg
`timescale 1ns / 1ps
`default_nettype none

module bls_stepper (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_advance,
    input  wire                              i_item_valid,
    input  bls_pkg::t_op                     i_operation,
    input  bls_pkg::t_line                   i_setup,
    input  wire [bls_pkg::COLOR_BITS-1:0]    i_color,
    output logic                             o_out_valid,
    output bls_pkg::t_out_item               o_out_item
);
    import bls_pkg::*;

    t_line                      r_line;
    t_line                      n_line;
    logic                       r_out_valid;
    logic                       n_out_valid;
    t_out_item                  r_out_item;
    t_out_item                  n_out_item;
    logic                       last;
    logic signed [ERR_BITS:0]   e_sum;
    logic signed [ERR_BITS:0]   e_adj;
    logic signed [ERR_BITS:0]   md_ext;
    logic                       minor_move;

    always_comb begin
        last       = r_line.maj_pos == r_line.maj_end;
        md_ext     = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, r_line.maj_delta});
        e_sum      = $signed({r_line.err[ERR_BITS-1], r_line.err})
                   + $signed({{(ERR_BITS+1-INC_BITS){1'b0}}, r_line.min_inc});
        minor_move = e_sum > md_ext;
        e_adj      = minor_move ? (e_sum - (md_ext <<< 1)) : e_sum;

        n_line      = r_line;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;

        if (i_advance) begin
            n_out_valid = 1'b0;
            if (i_item_valid) begin
                unique case (i_operation)
                    OP_LOAD: begin
                        n_line = i_setup;
                    end
                    OP_STEP: begin
                        if (r_line.active) begin
                            n_out_valid            = 1'b1;
                            n_out_item.pixel_x     = r_line.steep ? r_line.min_pos
                                                                  : r_line.maj_pos;
                            n_out_item.pixel_y     = r_line.steep ? r_line.maj_pos
                                                                  : r_line.min_pos;
                            n_out_item.pixel_color = i_color;
                            n_out_item.last_pixel  = last;
                            n_line.err             = e_adj[ERR_BITS-1:0];
                            if (minor_move) begin
                                n_line.min_pos = r_line.step_down ? r_line.min_pos - 1'b1
                                                                  : r_line.min_pos + 1'b1;
                            end
                            if (last) begin
                                n_line.active = 1'b0;
                            end else begin
                                n_line.maj_pos = r_line.maj_pos + 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_line = r_line;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### hw/rtl/bresenham_line_stepper.sv
// bresenham_line_stepper: top level of the integer line rasteriser
// input register, colour register, setup logic and stepper
// depends on bls_pkg, bls_setup, bls_stepper
//
// usage
//   input channel (i_in_valid, i_in_item, o_in_stall): a load item takes two
//   endpoints and gives no pixel; each step item then gives one pixel until
//   the pixel flagged last_pixel; a step with no line loaded gives nothing
//   output channel (o_out_valid, o_out_item, i_out_stall): one pixel item
//   with the current colour and the last-pixel flag
//   config channel (i_cfg_valid, i_cfg_data, o_cfg_ready): draw colour,
//   always ready, write it only while the block is idle
//   path: a step item is held in the input register, its pixel item in the result register
//   throughput: one item per cycle while the output is not stalled, as the error update
//   between the input register and the result register is combinational
//   reset: synchronous, active low; no line loaded, colour all ones
//   stall: a stalled result holds; the input register keeps taking items
//   while it is empty or the result register is free or being emptied,
//   else o_in_stall rises
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_stepper (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  bls_pkg::t_in_item                i_in_item,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output bls_pkg::t_out_item               o_out_item,
    input  wire                              i_out_stall,
    input  wire                              i_cfg_valid,
    input  wire [bls_pkg::COLOR_BITS-1:0]    i_cfg_data,
    output logic                             o_cfg_ready
);
    import bls_pkg::*;

    logic                  r_in_valid;
    t_in_item              r_in_item;
    logic [COLOR_BITS-1:0] r_color;
    logic                  advance;
    t_line                 setup_line;

    assign advance     = !o_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_color    <= COLOR_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_color <= i_cfg_data;
            end
        end
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    bls_setup u_setup (
        .i_item (r_in_item),
        .o_line (setup_line)
    );

    bls_stepper u_stepper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item_valid (r_in_valid),
        .i_operation  (r_in_item.operation),
        .i_setup      (setup_line),
        .i_color      (r_color),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire
